// ===== rtl/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg: shared definitions for the positional array list
// Request codes, status codes and the fixed widths of the request and
// result fields.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;
    localparam int EXT_W  = 64;

    localparam logic [REQ_W-1:0] OP_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] OP_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] OP_GET    = 3'd2;
    localparam logic [REQ_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [REQ_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list: fixed-capacity ordered list of data words
// A request is taken at a rising edge where start is high and busy is low.
// Insert, delete, get, search and clear operate on up to DEPTH words held in
// one synchronous memory with a registered read port.
//
// One result follows each request. It is shown for exactly one cycle with
// o_valid high; the receiver cannot stall it. busy stays high while a
// request is being worked on, so one request is in flight at a time.
// Clear, unknown codes and rejected requests are answered straight from idle;
// get reads the addressed word and returns it. Insert at p, with n the entry
// count, moves entries p to n - 1 up by one from the top down, then writes
// the new word at p; delete at p moves the entries above p down by one.
// Search reads from position 0 upward and ends at the first match, or after the last entry.
// The walks move one entry per cycle, paced by the single read and single
// write the memory allows each cycle; a read is overlapped with the write of
// the previous entry. Reset empties the list at once; the memory itself is
// not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [pal_pkg::REQ_W-1:0]  i_req_type,
    input  logic [pal_pkg::POS_W-1:0]  i_position,
    input  logic [pal_pkg::VAL_W-1:0]  i_value_in,
    output logic                       o_valid,
    output logic [pal_pkg::STAT_W-1:0] o_status,
    output logic [pal_pkg::VAL_W-1:0]  o_value_out,
    output logic                       o_found,
    output logic [pal_pkg::CNT_W-1:0]  o_count
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_GET,
        S_SRCH
    } t_state;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [CW-1:0]             r_k, n_k;
    logic [CW-1:0]             r_pos, n_pos;
    logic [DATA_WIDTH-1:0]     r_val, n_val;
    logic                      r_pend, n_pend;
    logic                      r_pend_vout, n_pend_vout;
    logic [AW-1:0]             r_dst, n_dst;
    logic [DATA_WIDTH-1:0]     r_vout, n_vout;
    logic                      r_valid, n_valid;
    logic [pal_pkg::STAT_W-1:0] r_status, n_status;
    logic [pal_pkg::VAL_W-1:0] r_value_out, n_value_out;
    logic                      r_found, n_found;
    logic [pal_pkg::CNT_W-1:0] r_count, n_count;

    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [DATA_WIDTH-1:0]     wr_data;

    logic [pal_pkg::EXT_W-1:0] in_ext;
    logic [pal_pkg::EXT_W-1:0] rdata_ext;
    logic [pal_pkg::EXT_W-1:0] vout_ext;
    logic [CMPW-1:0]           pos_x;
    logic [CMPW-1:0]           cnt_x;
    logic [CW-1:0]             pos_cw;
    logic [CW-1:0]             k_dec;
    logic [CW-1:0]             k_inc;

    assign in_ext    = pal_pkg::EXT_W'(i_value_in);
    assign rdata_ext = pal_pkg::EXT_W'(r_rdata);
    assign vout_ext  = pal_pkg::EXT_W'(r_vout);
    assign pos_x     = CMPW'(i_position);
    assign cnt_x     = CMPW'(r_cnt);
    assign pos_cw    = CW'(i_position);
    assign k_dec     = r_k - CW'(1);
    assign k_inc     = r_k + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_pos       = r_pos;
        n_val       = r_val;
        n_pend      = r_pend;
        n_pend_vout = r_pend_vout;
        n_dst       = r_dst;
        n_vout      = r_vout;
        n_valid     = 1'b0;
        n_status    = pal_pkg::ST_OK;
        n_value_out = '0;
        n_found     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val  = in_ext[DATA_WIDTH-1:0];
                    n_pos  = pos_cw;
                    n_pend = 1'b0;
                    case (i_req_type)
                        pal_pkg::OP_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_valid  = 1'b1;
                                n_status = pal_pkg::ST_RANGE;
                            end else if (r_cnt == CW'(DEPTH)) begin
                                n_valid  = 1'b1;
                                n_status = pal_pkg::ST_FULL;
                            end else begin
                                n_k     = r_cnt;
                                n_state = S_INS;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (pos_x >= cnt_x) begin
                                n_valid  = 1'b1;
                                n_status = pal_pkg::ST_RANGE;
                            end else begin
                                n_k     = pos_cw;
                                n_state = S_DEL;
                            end
                        end
                        pal_pkg::OP_GET: begin
                            if (pos_x >= cnt_x) begin
                                n_valid  = 1'b1;
                                n_status = pal_pkg::ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = pos_cw[AW-1:0];
                                n_state = S_GET;
                            end
                        end
                        pal_pkg::OP_SEARCH: begin
                            n_k     = '0;
                            n_state = S_SRCH;
                        end
                        pal_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst;
                    wr_data = r_rdata;
                end
                if (r_k > r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = k_dec[AW-1:0];
                    n_dst   = r_k[AW-1:0];
                    n_pend  = 1'b1;
                    n_k     = k_dec;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_val;
                    n_cnt   = r_cnt + CW'(1);
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DEL: begin
                if (r_pend) begin
                    if (r_pend_vout) begin
                        n_vout = r_rdata;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_dst;
                        wr_data = r_rdata;
                    end
                end
                if (r_k < r_cnt) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_k[AW-1:0];
                    n_pend      = 1'b1;
                    n_pend_vout = (r_k == r_pos);
                    n_dst       = k_dec[AW-1:0];
                    n_k         = k_inc;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_cnt       = r_cnt - CW'(1);
                    n_valid     = 1'b1;
                    n_value_out = vout_ext[pal_pkg::VAL_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            S_GET: begin
                n_valid     = 1'b1;
                n_value_out = rdata_ext[pal_pkg::VAL_W-1:0];
                n_state     = S_IDLE;
            end
            S_SRCH: begin
                if (r_pend && (r_rdata == r_val)) begin
                    n_pend      = 1'b0;
                    n_valid     = 1'b1;
                    n_found     = 1'b1;
                    n_value_out = rdata_ext[pal_pkg::VAL_W-1:0];
                    n_state     = S_IDLE;
                end else if (r_k < r_cnt) begin
                    rd_en   = 1'b1;
                    rd_addr = r_k[AW-1:0];
                    n_pend  = 1'b1;
                    n_k     = k_inc;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count = pal_pkg::CNT_W'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_valid     <= n_valid;
            r_k         <= n_k;
            r_pos       <= n_pos;
            r_val       <= n_val;
            r_pend_vout <= n_pend_vout;
            r_dst       <= n_dst;
            r_vout      <= n_vout;
            r_status    <= n_status;
            r_value_out <= n_value_out;
            r_found     <= n_found;
            r_count     <= n_count;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_found     = r_found;
    assign o_count     = r_count;

endmodule
